// ===== design/touch_coordinate_smoother_defines.svh =====
// ----------------------------------------------------------------------------
// touch coordinate smoother assertion macros
// shared property wrappers for the concurrent checks of the smoother
// ----------------------------------------------------------------------------
`ifndef TOUCH_COORDINATE_SMOOTHER_DEFINES_SVH
`define TOUCH_COORDINATE_SMOOTHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCS_ASSERT_NOW(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error("touch smoother check failed");

// next-cycle implication, disabled in reset
`define TCS_ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error("touch smoother check failed");

`endif

// ===== design/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg
// shared constants and types of the touch coordinate smoother
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int RAW_W   = 12;
  localparam int MS_W    = 16;
  localparam int ALPHA_W = 9;
  localparam int SX_W    = 9;
  localparam int SY_W    = 8;
  localparam int FILT_W  = 25;  // signed q16.8
  localparam int POS_W   = 17;  // signed integer part
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int POS_MIN = -65536;
  localparam int POS_MAX = 65535;
  localparam int ALPHA_ONE = 256;

  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SZ_W  = $clog2(SIZE_MAX + 1);
  // magnitude of (raw - min) * size
  localparam int NUM_W = $clog2(4095 * SIZE_MAX + 1);
  localparam int DEN_W = RAW_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RESET_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CAL_MIN          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CAL_MAX          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CAL_MIN          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CAL_MAX          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA    = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/tcs_div.sv =====
// ----------------------------------------------------------------------------
// tcs_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tcs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tcs_pkg::NUM_W-1:0]  dividend,
  input  logic [tcs_pkg::DEN_W-1:0]  divisor,
  output tcs_pkg::div_stat_t         stat,
  output logic [tcs_pkg::NUM_W-1:0]  quotient
);

  localparam int NW = tcs_pkg::NUM_W;
  localparam int DW = tcs_pkg::DEN_W;
  localparam int CW = tcs_pkg::CNT_W;

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          sub_ok;

  assign shifted = {rem, quo[NW-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign sub_ok  = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= sub_ok ? trial[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], sub_ok};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== design/touch_coordinate_smoother.sv =====
// ----------------------------------------------------------------------------
// touch_coordinate_smoother
// a sample that is not a touch goes from the request straight to the done step
// a touch at 320x240 runs two axis passes, screen x then screen y, each of
//   (setup, 21-step shared divider and its done, skipped on a zero span, map, multiply, update)
//   then the done step and the output register load
// throughput: one request at a time; next request taken once the result is loaded
// reset: synchronous, registers to defaults, filters zero, idle time saturated
// ----------------------------------------------------------------------------
`include "touch_coordinate_smoother_defines.svh"

module touch_coordinate_smoother (
  input  logic                            clk,
  input  logic                            rst,
  // sample requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            read_ok,
  input  logic [tcs_pkg::RAW_W-1:0]       raw_x,
  input  logic [tcs_pkg::RAW_W-1:0]       raw_y,
  input  logic [tcs_pkg::RAW_W-1:0]       raw_pressure,
  input  logic [tcs_pkg::MS_W-1:0]        elapsed_ms,
  // result requests
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_touched,
  output logic [tcs_pkg::SX_W-1:0]        screen_x,
  output logic [tcs_pkg::SY_W-1:0]        screen_y,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW  = tcs_pkg::RAW_W;
  localparam int MSW = tcs_pkg::MS_W;
  localparam int AW  = tcs_pkg::ALPHA_W;
  localparam int FW  = tcs_pkg::FILT_W;
  localparam int PW  = tcs_pkg::POS_W;
  localparam int SZW = tcs_pkg::SZ_W;
  localparam int NW  = tcs_pkg::NUM_W;
  localparam int QW  = NW + 1;
  // mapped value before saturation, wide enough for the q16.8 integer range
  localparam int MW  = (NW + 2 > PW + 1) ? NW + 2 : PW + 1;
  localparam int DW  = FW + 1;
  localparam int PRW = DW + AW + 1;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MAP   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [RW-1:0]  pressure_threshold;
  logic [MSW-1:0] idle_reset_ms;
  logic [RW-1:0]  x_cal_min;
  logic [RW-1:0]  x_cal_max;
  logic [RW-1:0]  y_cal_min;
  logic [RW-1:0]  y_cal_max;
  logic [AW-1:0]  smoothing_alpha;

  // filter state
  logic signed [FW-1:0] filter_x;
  logic signed [FW-1:0] filter_y;
  logic [MSW-1:0]       idle_ms;

  // captured request and working registers
  logic [RW-1:0]         samp_x;
  logic [RW-1:0]         samp_y;
  logic                  touched;
  logic                  seed;
  logic                  axis;     // 0 works on screen x, 1 on screen y
  logic                  neg;
  logic signed [QW-1:0]  q_reg;
  logic signed [FW-1:0]  base;
  logic signed [DW-1:0]  delta;
  logic signed [PRW-1:0] prod;

  // ---- request side --------------------------------------------------------
  logic            in_fire;
  logic            touched_now;
  logic [MSW:0]    idle_sum;
  logic [MSW-1:0]  idle_sat;

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign touched_now = read_ok && (raw_pressure > pressure_threshold);
  assign idle_sum    = {1'b0, idle_ms} + {1'b0, elapsed_ms};
  // idle time saturates at all ones
  assign idle_sat    = idle_sum[MSW] ? '1 : idle_sum[MSW-1:0];

  assign cfg_ready = 1'b1;

  // ---- axis selection: swapped axes, raw y drives screen x -----------------
  logic [RW-1:0]         raw_sel;
  logic [RW-1:0]         lo_sel;
  logic [RW-1:0]         hi_sel;
  logic [SZW-1:0]        size_sel;
  logic [SZW-1:0]        size_m1;
  logic signed [RW:0]    diff;
  logic signed [RW:0]    den;
  logic [RW:0]           diff_abs;
  logic [RW:0]           den_abs;
  logic [RW+SZW-1:0]     num_full;
  logic                  div_start;

  assign raw_sel  = axis ? samp_x : samp_y;
  assign lo_sel   = axis ? y_cal_min : x_cal_min;
  assign hi_sel   = axis ? y_cal_max : x_cal_max;
  assign size_sel = axis ? SZW'(tcs_pkg::SCREEN_HEIGHT) : SZW'(tcs_pkg::SCREEN_WIDTH);
  assign size_m1  = size_sel - 1'b1;

  assign diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, lo_sel});
  assign den      = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
  assign diff_abs = diff[RW] ? -diff : diff;
  assign den_abs  = den[RW] ? -den : den;
  // span offset times screen size, always a small constant multiply
  assign num_full = diff_abs[RW-1:0] * size_sel;

  // zero span skips the divider and maps to zero quotient
  assign div_start = (state == S_SETUP) && (den != '0);

  tcs_pkg::div_stat_t  div_stat;
  logic [NW-1:0]       div_quo;

  tcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_full[NW-1:0]),
    .divisor  (den_abs[RW-1:0]),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  logic signed [QW-1:0] q_ext;
  assign q_ext = $signed({1'b0, div_quo});

  // ---- map, mirror and saturate to the q16.8 integer range -----------------
  logic signed [MW-1:0] m_full;
  logic signed [MW-1:0] m_lo;
  logic signed [MW-1:0] m_hi;
  logic signed [PW-1:0] m_sat;
  logic signed [FW-1:0] big_m;
  logic signed [FW-1:0] f_sel;
  logic signed [FW-1:0] base_next;
  logic signed [DW-1:0] delta_next;

  assign m_lo   = MW'(tcs_pkg::POS_MIN);
  assign m_hi   = MW'(tcs_pkg::POS_MAX);
  assign m_full = $signed({{(MW-SZW){1'b0}}, size_m1}) - {{(MW-QW){q_reg[QW-1]}}, q_reg};

  always_comb begin
    if (m_full < m_lo) begin
      m_sat = m_lo[PW-1:0];
    end else if (m_full > m_hi) begin
      m_sat = m_hi[PW-1:0];
    end else begin
      m_sat = m_full[PW-1:0];
    end
  end

  assign big_m     = {m_sat, 8'd0};
  assign f_sel     = axis ? filter_y : filter_x;
  // seeding puts the new position straight into the filter
  assign base_next = seed ? big_m : f_sel;
  // f*(256-a) + m*256*a over 256 equals f + floor((m*256 - f)*a / 256)
  assign delta_next = {big_m[FW-1], big_m} - {base_next[FW-1], base_next};

  logic [AW-1:0]        a_sat;
  logic signed [FW-1:0] f_new;

  assign a_sat = (smoothing_alpha > AW'(tcs_pkg::ALPHA_ONE)) ? AW'(tcs_pkg::ALPHA_ONE)
                                                            : smoothing_alpha;
  // arithmetic shift drops the fraction, i.e. floor
  assign f_new = base + prod[FW+7:8];

  // ---- output clamp --------------------------------------------------------
  logic signed [PW-1:0] vx;
  logic signed [PW-1:0] vy;
  logic signed [PW-1:0] x_max;
  logic signed [PW-1:0] y_max;
  logic signed [PW-1:0] cx;
  logic signed [PW-1:0] cy;

  assign vx    = filter_x[FW-1:8];
  assign vy    = filter_y[FW-1:8];
  assign x_max = PW'(tcs_pkg::SCREEN_WIDTH - 1);
  assign y_max = PW'(tcs_pkg::SCREEN_HEIGHT - 1);

  always_comb begin
    if (vx < 0) begin
      cx = '0;
    end else if (vx > x_max) begin
      cx = x_max;
    end else begin
      cx = vx;
    end
    if (vy < 0) begin
      cy = '0;
    end else if (vy > y_max) begin
      cy = y_max;
    end else begin
      cy = vy;
    end
  end

  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // ---- sequencer -----------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = touched_now ? S_SETUP : S_DONE;
        end
      end
      S_SETUP: begin
        state_next = (den != '0) ? S_DIV : S_MAP;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = axis ? S_DONE : S_SETUP;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      axis               <= 1'b0;
      out_valid          <= 1'b0;
      idle_ms            <= '1;
      filter_x           <= '0;
      filter_y           <= '0;
      pressure_threshold <= RW'(400);
      idle_reset_ms      <= MSW'(200);
      x_cal_min          <= RW'(300);
      x_cal_max          <= RW'(3800);
      y_cal_min          <= RW'(300);
      y_cal_max          <= RW'(3800);
      smoothing_alpha    <= AW'(77);
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcs_pkg::CFG_PRESSURE_THRESHOLD: pressure_threshold <= cfg_data[RW-1:0];
          tcs_pkg::CFG_IDLE_RESET_MS:      idle_reset_ms      <= cfg_data[MSW-1:0];
          tcs_pkg::CFG_X_CAL_MIN:          x_cal_min          <= cfg_data[RW-1:0];
          tcs_pkg::CFG_X_CAL_MAX:          x_cal_max          <= cfg_data[RW-1:0];
          tcs_pkg::CFG_Y_CAL_MIN:          y_cal_min          <= cfg_data[RW-1:0];
          tcs_pkg::CFG_Y_CAL_MAX:          y_cal_max          <= cfg_data[RW-1:0];
          tcs_pkg::CFG_SMOOTHING_ALPHA:    smoothing_alpha    <= cfg_data[AW-1:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        axis    <= 1'b0;
        // an accepted touch restarts the idle time
        idle_ms <= touched_now ? '0 : idle_sat;
      end

      if (state == S_UPD) begin
        if (axis) begin
          filter_y <= f_new;
        end else begin
          filter_x <= f_new;
        end
        axis <= ~axis;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      samp_x  <= raw_x;
      samp_y  <= raw_y;
      touched <= touched_now;
      seed    <= (idle_sat > idle_reset_ms);
    end
    if (state == S_SETUP) begin
      neg <= diff[RW] ^ den[RW];
      if (den == '0) begin
        q_reg <= '0;
      end
    end
    if ((state == S_DIV) && div_stat.done) begin
      q_reg <= neg ? -q_ext : q_ext;
    end
    if (state == S_MAP) begin
      base  <= base_next;
      delta <= delta_next;
    end
    if (state == S_MUL) begin
      prod <= delta * $signed({1'b0, a_sat});
    end
    if (out_load) begin
      is_touched <= touched;
      screen_x   <= touched ? cx[tcs_pkg::SX_W-1:0] : '0;
      screen_y   <= touched ? cy[tcs_pkg::SY_W-1:0] : '0;
    end
  end

  // ---- checks --------------------------------------------------------------
  // divider finishes only while the sequencer waits on it
  `TCS_ASSERT_NOW(a_div_done_in_wait, clk, rst, div_stat.done, state == S_DIV)
  // a touch clears the idle time on the next cycle
  `TCS_ASSERT_NEXT(a_touch_clears_idle, clk, rst, in_fire && touched_now, idle_ms == '0)
  // a taken result with nothing new behind it empties the output register
  `TCS_ASSERT_NEXT(a_out_drains, clk, rst, out_valid && out_ready && (state != S_DONE),
                   !out_valid)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for touch_coordinate_smoother: a local predictor of the
// calibrate, mirror and smooth path checks every result against the requests
// sent, over directed corner cases and randomly configured random traffic
// ----------------------------------------------------------------------------
module tb;

  localparam int RAW_W         = tcs_pkg::RAW_W;
  localparam int MS_W          = tcs_pkg::MS_W;
  localparam int SX_W          = tcs_pkg::SX_W;
  localparam int SY_W          = tcs_pkg::SY_W;
  localparam int ALPHA_W       = tcs_pkg::ALPHA_W;
  localparam int CFG_IDX_W     = tcs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = tcs_pkg::CFG_DATA_W;
  localparam int ALPHA_ONE     = tcs_pkg::ALPHA_ONE;
  localparam int POS_MIN       = tcs_pkg::POS_MIN;
  localparam int POS_MAX       = tcs_pkg::POS_MAX;
  localparam int SCREEN_WIDTH  = tcs_pkg::SCREEN_WIDTH;
  localparam int SCREEN_HEIGHT = tcs_pkg::SCREEN_HEIGHT;

  // longest run of cycles with no handshake on any channel
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 408;

  typedef struct packed {
    logic              read_ok;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_pressure;
    logic [MS_W-1:0]   elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic              is_touched;
    logic [SX_W-1:0]   screen_x;
    logic [SY_W-1:0]   screen_y;
  } position_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic                   read_ok      = 1'b0;
  logic [RAW_W-1:0]       raw_x        = '0;
  logic [RAW_W-1:0]       raw_y        = '0;
  logic [RAW_W-1:0]       raw_pressure = '0;
  logic [MS_W-1:0]        elapsed_ms   = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic                   is_touched;
  logic [SX_W-1:0]        screen_x;
  logic [SY_W-1:0]        screen_y;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index    = tcs_pkg::CFG_PRESSURE_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  touch_coordinate_smoother dut (.*);

  always #5 clk = ~clk;

  // percent of cycles in which each side holds off
  int send_idle_pct = 27;
  int recv_idle_pct = 54;

  int errors       = 0;
  int stall_cycles = 0;

  // results still owed by the block, oldest first
  position_t pending_positions[$];
  position_t got;

  // ---------------------------------------------------------------------------
  // mirror of the register file, reset values
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0]   touch_threshold = 12'd400;
  logic [MS_W-1:0]    reseed_after_ms = 16'd200;
  logic [RAW_W-1:0]   x_span_lo       = 12'd300;
  logic [RAW_W-1:0]   x_span_hi       = 12'd3800;
  logic [RAW_W-1:0]   y_span_lo       = 12'd300;
  logic [RAW_W-1:0]   y_span_hi       = 12'd3800;
  logic [ALPHA_W-1:0] blend_weight    = 9'd77;

  // filter state: q16.8 positions and the idle time, saturated after reset
  longint      smooth_x = 0;
  longint      smooth_y = 0;
  int unsigned quiet_ms = 32'hFFFF;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // linear map through the calibration span, then mirrored and saturated to
  // the integer range of q16.8; a zero span maps onto the far edge
  function automatic longint map_to_screen(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                           logic [RAW_W-1:0] hi, longint size);
    longint r, l, h, q, m;
    r = longint'(raw);
    l = longint'(lo);
    h = longint'(hi);
    q = (h == l) ? 0 : ((r - l) * size) / (h - l);  // truncates toward zero
    m = size - 1 - q;
    if (m < POS_MIN) m = POS_MIN;
    if (m > POS_MAX) m = POS_MAX;
    return m;
  endfunction

  // exponential blend, floor division by 256 via arithmetic shift
  function automatic longint blend_filter(longint f, longint m, longint w);
    return (f * (ALPHA_ONE - w) + m * 256 * w) >>> 8;
  endfunction

  function automatic longint clamp_to_screen(longint f, longint size);
    longint v;
    v = f >>> 8;
    if (v < 0) v = 0;
    if (v > size - 1) v = size - 1;
    return v;
  endfunction

  // advances the mirror by one sample and returns the position it should give
  function automatic position_t next_position(sample_t s);
    position_t p;
    longint    w, mx, my;
    p = '0;
    quiet_ms = quiet_ms + 32'(s.elapsed_ms);
    if (quiet_ms > 32'hFFFF) quiet_ms = 32'hFFFF;
    // failed read or light press: nothing moves
    if (!s.read_ok || s.raw_pressure <= touch_threshold) return p;
    w  = (blend_weight > ALPHA_W'(ALPHA_ONE)) ? longint'(ALPHA_ONE) : longint'(blend_weight);
    // axes are swapped: raw y drives screen x
    mx = map_to_screen(s.raw_y, x_span_lo, x_span_hi, longint'(SCREEN_WIDTH));
    my = map_to_screen(s.raw_x, y_span_lo, y_span_hi, longint'(SCREEN_HEIGHT));
    // long lift: seed the filter at the new spot before blending
    if (quiet_ms > 32'(reseed_after_ms)) begin
      smooth_x = mx * 256;
      smooth_y = my * 256;
    end
    smooth_x = blend_filter(smooth_x, mx, w);
    smooth_y = blend_filter(smooth_y, my, w);
    quiet_ms = 0;
    p.is_touched = 1'b1;
    p.screen_x   = SX_W'(clamp_to_screen(smooth_x, longint'(SCREEN_WIDTH)));
    p.screen_y   = SY_W'(clamp_to_screen(smooth_y, longint'(SCREEN_HEIGHT)));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random backpressure, result checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        $error("result with no request outstanding: touched %0d x %0d y %0d",
               is_touched, screen_x, screen_y);
        errors++;
      end else begin
        got = pending_positions.pop_front();
        if (is_touched !== got.is_touched) begin
          $error("is_touched: expected %0d, got %0d", got.is_touched, is_touched);
          errors++;
        end
        if (screen_x !== got.screen_x) begin
          $error("screen_x: expected %0d, got %0d", got.screen_x, screen_x);
          errors++;
        end
        if (screen_y !== got.screen_y) begin
          $error("screen_y: expected %0d, got %0d", got.screen_y, screen_y);
          errors++;
        end
      end
    end
  end

  // any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back requests; it only drops for an idle
  // cycle or when settle() takes the sender quiet
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    read_ok      <= s.read_ok;
    raw_x        <= s.raw_x;
    raw_y        <= s.raw_y;
    raw_pressure <= s.raw_pressure;
    elapsed_ms   <= s.elapsed_ms;
    pending_positions.push_back(next_position(s));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic sample_t make_sample(logic ok, logic [RAW_W-1:0] rx,
                                          logic [RAW_W-1:0] ry, logic [RAW_W-1:0] pr,
                                          logic [MS_W-1:0] el);
    sample_t s;
    s.read_ok      = ok;
    s.raw_x        = rx;
    s.raw_y        = ry;
    s.raw_pressure = pr;
    s.elapsed_ms   = el;
    return s;
  endfunction

  // sender goes quiet until every owed result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; cfg_valid is lowered by the caller after the last one
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tcs_pkg::CFG_PRESSURE_THRESHOLD: touch_threshold = data[RAW_W-1:0];
      tcs_pkg::CFG_IDLE_RESET_MS:      reseed_after_ms = data[MS_W-1:0];
      tcs_pkg::CFG_X_CAL_MIN:          x_span_lo       = data[RAW_W-1:0];
      tcs_pkg::CFG_X_CAL_MAX:          x_span_hi       = data[RAW_W-1:0];
      tcs_pkg::CFG_Y_CAL_MIN:          y_span_lo       = data[RAW_W-1:0];
      tcs_pkg::CFG_Y_CAL_MAX:          y_span_hi       = data[RAW_W-1:0];
      tcs_pkg::CFG_SMOOTHING_ALPHA:    blend_weight    = data[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // full register set, written only once the block has drained
  task automatic configure(input logic [CFG_DATA_W-1:0] thresh, reseed, xlo, xhi,
                           ylo, yhi, weight);
    settle();
    write_register(tcs_pkg::CFG_PRESSURE_THRESHOLD, thresh);
    write_register(tcs_pkg::CFG_IDLE_RESET_MS, reseed);
    write_register(tcs_pkg::CFG_X_CAL_MIN, xlo);
    write_register(tcs_pkg::CFG_X_CAL_MAX, xhi);
    write_register(tcs_pkg::CFG_Y_CAL_MIN, ylo);
    write_register(tcs_pkg::CFG_Y_CAL_MAX, yhi);
    write_register(tcs_pkg::CFG_SMOOTHING_ALPHA, weight);
    cfg_valid <= 1'b0;
  endtask

  // calibration span: mostly a sane panel, sometimes inverted, arbitrary or
  // empty, now and then with junk above the register width
  task automatic pick_span(output logic [CFG_DATA_W-1:0] lo, hi);
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      lo = CFG_DATA_W'($urandom_range(800));
      hi = CFG_DATA_W'($urandom_range(4095, 3000));
    end else if (pick < 85) begin
      hi = CFG_DATA_W'($urandom_range(800));
      lo = CFG_DATA_W'($urandom_range(4095, 3000));
    end else if (pick < 95) begin
      lo = CFG_DATA_W'($urandom_range(4095));
      hi = CFG_DATA_W'($urandom_range(4095));
    end else begin
      lo = CFG_DATA_W'($urandom_range(4095));
      hi = lo;
    end
    if ($urandom_range(9) == 0) begin
      lo[CFG_DATA_W-1:RAW_W] = (CFG_DATA_W-RAW_W)'($urandom);
      hi[CFG_DATA_W-1:RAW_W] = (CFG_DATA_W-RAW_W)'($urandom);
    end
  endtask

  task automatic configure_random();
    logic [CFG_DATA_W-1:0] thresh, reseed, xlo, xhi, ylo, yhi, weight;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)      thresh = CFG_DATA_W'($urandom_range(800));
    else if (pick < 88) thresh = CFG_DATA_W'($urandom_range(4095));
    else if (pick < 96) thresh = '0;
    else                thresh = 16'd4095;
    if ($urandom_range(9) == 0) thresh[CFG_DATA_W-1:RAW_W] = (CFG_DATA_W-RAW_W)'($urandom);
    pick = $urandom_range(99);
    if (pick < 50)      reseed = CFG_DATA_W'($urandom_range(300));
    else if (pick < 80) reseed = CFG_DATA_W'($urandom_range(65535));
    else if (pick < 90) reseed = '0;
    else                reseed = 16'hFFFF;
    pick_span(xlo, xhi);
    pick_span(ylo, yhi);
    pick = $urandom_range(99);
    if (pick < 70)      weight = CFG_DATA_W'($urandom_range(256, 1));
    else if (pick < 80) weight = '0;
    else if (pick < 90) weight = CFG_DATA_W'(ALPHA_ONE);
    else                weight = CFG_DATA_W'($urandom_range(511, 257));  // saturates to one
    if ($urandom_range(9) == 0) weight[CFG_DATA_W-1:ALPHA_W] = (CFG_DATA_W-ALPHA_W)'($urandom);
    configure(thresh, reseed, xlo, xhi, ylo, yhi, weight);
  endtask

  // mostly firm presses inside the panel span with short gaps, plus noise
  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    s.read_ok = ($urandom_range(99) < 92);
    pick = $urandom_range(99);
    if (pick < 70)
      s.raw_pressure = (touch_threshold == 12'hFFF) ? 12'hFFF :
                       RAW_W'($urandom_range(4095, touch_threshold + 1));
    else if (pick < 80)
      s.raw_pressure = touch_threshold;
    else
      s.raw_pressure = RAW_W'($urandom_range(4095));
    s.raw_y = ($urandom_range(4) != 0) ? RAW_W'($urandom_range(x_span_lo, x_span_hi))
                                       : RAW_W'($urandom_range(4095));
    s.raw_x = ($urandom_range(4) != 0) ? RAW_W'($urandom_range(y_span_lo, y_span_hi))
                                       : RAW_W'($urandom_range(4095));
    pick = $urandom_range(99);
    if (pick < 70)      s.elapsed_ms = MS_W'($urandom_range(30));
    else if (pick < 88) s.elapsed_ms = MS_W'($urandom_range(2000));
    else if (pick < 94) s.elapsed_ms = 16'hFFFF;
    else                s.elapsed_ms = MS_W'($urandom_range(65535));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values, first touch and idle gap handling
  task automatic test_power_up_defaults();
    send_sample(make_sample(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 16'd0));  // failed read
    send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 12'd400, 16'd0));  // at threshold
    send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 12'd401, 16'd0));  // seeds filter
    send_sample(make_sample(1'b1, 12'hFFF, 12'd0, 12'd3000, 16'd10));  // drag to corner
    send_sample(make_sample(1'b1, 12'd0, 12'hFFF, 12'hFFF, 16'd200));  // gap at limit
    send_sample(make_sample(1'b1, 12'd0, 12'hFFF, 12'hFFF, 16'd201));  // gap past limit
    send_sample(make_sample(1'b0, 12'd0, 12'd0, 12'd0, 16'hFFFF));  // idle saturates
    send_sample(make_sample(1'b1, 12'hAAA, 12'h555, 12'h800, 16'hFFFF));
    settle();
  endtask

  // each register at its extremes, empty and inverted spans, mapping overflow
  task automatic test_register_extremes();
    // zero threshold and zero reseed time, empty x span, inverted y span,
    // alpha zero freezes the filter at its seed
    configure(16'd0, 16'd0, 16'd2048, 16'd2048, 16'd4095, 16'd0, 16'd0);
    send_sample(make_sample(1'b1, 12'd1000, 12'd1000, 12'd0, 16'd5));
    send_sample(make_sample(1'b1, 12'd1000, 12'd1000, 12'd1, 16'd5));
    send_sample(make_sample(1'b1, 12'd3000, 12'd100, 12'd1, 16'd0));
    send_sample(make_sample(1'b1, 12'd3000, 12'd100, 12'd1, 16'd1));
    // top threshold: nothing can press hard enough
    configure(16'd4095, 16'd200, 16'd300, 16'd3800, 16'd300, 16'd3800, 16'd77);
    send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 12'hFFF, 16'd0));
    // one-count spans drive the mapping past q16.8 both ways, alpha above one
    configure(16'd100, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd1, 16'd511);
    send_sample(make_sample(1'b1, 12'hFFF, 12'hFFF, 12'd500, 16'hFFFF));
    send_sample(make_sample(1'b1, 12'd0, 12'd0, 12'hFFF, 16'd0));
    // junk above each register width must be dropped; alpha ends up as one lsb
    configure(16'hF032, 16'd10, 16'hF12C, 16'h0ED8, 16'h712C, 16'h8ED8, 16'hFE01);
    send_sample(make_sample(1'b1, 12'd2048, 12'd2048, 12'd51, 16'd11));
    send_sample(make_sample(1'b1, 12'd300, 12'd300, 12'hFFF, 16'd3));
    send_sample(make_sample(1'b1, 12'd3800, 12'd3800, 12'd50, 16'd3));
    // alpha exactly one: output follows the raw position
    configure(16'd400, 16'd200, 16'd300, 16'd3800, 16'd300, 16'd3800, 16'd256);
    send_sample(make_sample(1'b1, 12'd1234, 12'd3210, 12'd1000, 16'd1));
    send_sample(make_sample(1'b1, 12'd3210, 12'd1234, 12'd1000, 16'd1));
    settle();
  endtask

  // random settings and samples under the given idling on each side
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      configure_random();
      repeat (RANDOM_PER_PHASE / 4) begin
        send_sample(random_sample());
        // now and then hold off until the block has fully drained
        if ($urandom_range(99) == 0) settle();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_power_up_defaults();
    test_register_extremes();
    test_random_traffic(27, 54);
    test_random_traffic(54, 27);
    test_random_traffic(0, 0);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_positions.size() != 0) begin
      $error("%0d results never arrived", pending_positions.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
